### src/wbs_pkg.sv
// ----------------------------------------------------------------------------
// Wildcard byte signature scanner package
// Shared types and fixed widths for the scanner, its cells and its interfaces.
// ----------------------------------------------------------------------------
package wbs_pkg;

    // Fixed field widths of the channels and registers.
    localparam int BYTE_W     = 8;
    localparam int SIG_BYTES  = 16;
    localparam int SIG_W      = 64;
    localparam int MASK_W     = 16;
    localparam int LENGTH_W   = 5;
    localparam int WANTED_W   = 16;
    localparam int BASE_W     = 32;
    localparam int ADDR_OUT_W = 32;
    localparam int CFG_IDX_W  = 3;

    typedef logic [BYTE_W-1:0] t_byte;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LOW  = 3'd0,
        REG_PATTERN_HIGH = 3'd1,
        REG_WILDCARD     = 3'd2,
        REG_LENGTH       = 3'd3,
        REG_WANTED       = 3'd4,
        REG_IMAGE_BASE   = 3'd5
    } t_reg_idx;

    // Candidate handed from the window stage to the result stage.
    typedef struct packed {
        logic valid;
        logic last;
        logic hit;
    } t_cand;

endpackage

### src/wbs_in_if.sv
// ----------------------------------------------------------------------------
// Image byte channel
// Valid/ready stream carrying one image byte and its end-of-image flag.
// ----------------------------------------------------------------------------
interface wbs_in_if import wbs_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte data_byte;
    logic  last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

### src/wbs_out_if.sv
// ----------------------------------------------------------------------------
// Scan result channel
// Valid/ready stream carrying the found flag and the match start address.
// ----------------------------------------------------------------------------
interface wbs_out_if import wbs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  found;
    logic [ADDR_OUT_W-1:0] match_address;

    modport source (output valid, output found, output match_address, input ready);
    modport sink   (input valid, input found, input match_address, output ready);
endinterface

### src/wbs_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready write port carrying a register index and write data.
// ----------------------------------------------------------------------------
interface wbs_cfg_if import wbs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [SIG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### src/wbs_cell.sv
// ----------------------------------------------------------------------------
// Scanner window cell
// Holds one window byte, passes it to its neighbor on every shift and
// folds its own byte compare into the running match chain.
// ----------------------------------------------------------------------------
module wbs_cell import wbs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_shift,
    input  t_byte i_byte,
    input  t_byte i_sig,
    input  logic  i_care,
    input  logic  i_hit,
    output t_byte o_byte,
    output logic  o_hit
);

    t_byte r_byte;

    // Window byte moves one place down the chain per accepted transaction.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;

    // A wildcard or unused position always agrees.
    assign o_hit = i_hit & (~i_care | (r_byte == i_sig));

endmodule

### src/wbs_result.sv
// ----------------------------------------------------------------------------
// Scanner result stage
// Counts matches, picks the requested occurrence, reports not-found at the
// end of an image and holds the result in the output register.
// ----------------------------------------------------------------------------
module wbs_result import wbs_pkg::*; #(
    parameter int ADDRESS_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cand                    i_cand,
    input  logic [ADDRESS_WIDTH-1:0] i_start,
    input  logic [BASE_W-1:0]        i_image_base,
    input  logic [WANTED_W-1:0]      i_wanted,
    output logic                     o_adv,
    wbs_out_if.source                o_out
);

    logic                  r_out_valid;
    logic                  r_found;
    logic [ADDR_OUT_W-1:0] r_addr;
    logic [WANTED_W-1:0]   r_matches;
    logic                  r_reported;

    logic                     fire;
    logic                     match;
    logic                     emit_found;
    logic                     emit_nf;
    logic [ADDRESS_WIDTH-1:0] addr_sum;

    // The stage moves whenever the output register is free or being drained.
    assign o_adv = ~r_out_valid | o_out.ready;
    assign fire  = i_cand.valid & o_adv;

    // Match decision for the candidate in the window stage.
    assign match      = i_cand.hit & ~r_reported;
    assign emit_found = match & (r_matches == i_wanted);
    assign emit_nf    = i_cand.last & ~r_reported & ~emit_found;

    // Start address wraps at the address width.
    assign addr_sum = ADDRESS_WIDTH'(i_image_base) + i_start;

    // Occurrence counter and report flag; the final byte clears both.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matches  <= '0;
            r_reported <= 1'b0;
        end else if (fire) begin
            if (i_cand.last) begin
                r_matches  <= '0;
                r_reported <= 1'b0;
            end else if (emit_found) begin
                r_reported <= 1'b1;
            end else if (match) begin
                r_matches <= r_matches + 1'b1;
            end
        end
    end

    // Output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_adv) begin
            r_out_valid <= fire & (emit_found | emit_nf);
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_found <= emit_found;
            r_addr  <= emit_found ? ADDR_OUT_W'(addr_sum) : '0;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.found         = r_found;
    assign o_out.match_address = r_addr;

    // A not-found result always carries a zero address.
    a_nf_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_found |-> r_addr == '0)
        else $error("not-found result with nonzero address");

    // Reporting an occurrence mid-image blocks further results.
    a_found_sets_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && emit_found && !i_cand.last |=> r_reported)
        else $error("report flag not set after found result");

    // A new result only comes from a candidate consumed in the cycle before.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(fire))
        else $error("result appeared without a consumed candidate");

    // Once reported, the occurrence count stays put until the image ends.
    a_count_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_reported && !(fire && i_cand.last) |=> $stable(r_matches))
        else $error("match count moved after report");

endmodule

### src/wildcard_byte_signature_scanner.sv
// ----------------------------------------------------------------------------
// Wildcard byte signature scanner
// Streams a memory image one byte per transaction and reports the start
// address of the requested occurrence of a wildcard byte signature.
// ----------------------------------------------------------------------------
// Usage:
//   i_in   carries one image byte per transaction; last_byte marks the end
//          of the image and returns the scan state to its start.
//   o_out  carries at most one result per image: found with the start
//          address (image base plus offset, wrapping), or not-found with
//          address zero on the final byte.
//   i_cfg  writes the signature, wildcard mask, length, wanted occurrence
//          and image base by register index; always ready. Write only
//          while no byte is in flight.
//   Throughput is one byte per cycle while the result stage is not stalled:
//   the window is a chain of byte cells that shifts once per transaction,
//   and the compare of the full window completes in the following cycle.
//   A byte passes the window shift into the cells and stage registers, then
//   the match decision into the output register.
//   Reset clears the scan state and loads the register defaults (length 1).
//   When the receiver stalls, the window stage still takes one more byte;
//   after that i_in.ready stays low until the result is taken.
// ----------------------------------------------------------------------------
module wildcard_byte_signature_scanner import wbs_pkg::*; #(
    parameter int PATTERN_MAX   = 16,
    parameter int ADDRESS_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wbs_in_if.sink    i_in,
    wbs_out_if.source o_out,
    wbs_cfg_if.sink   i_cfg
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    // Configuration registers.
    logic [SIG_W-1:0]    r_pattern_low;
    logic [SIG_W-1:0]    r_pattern_high;
    logic [MASK_W-1:0]   r_wildcard;
    logic [LENGTH_W-1:0] r_pattern_length;
    logic [WANTED_W-1:0] r_wanted;
    logic [BASE_W-1:0]   r_image_base;

    // Window stage state.
    logic                     r_prev_last;
    logic [LEN_W-1:0]         r_fill;
    logic [ADDRESS_WIDTH-1:0] r_pos;
    logic                     r_a_valid;
    logic                     r_a_last;
    logic [ADDRESS_WIDTH-1:0] r_a_start;

    logic [LEN_W-1:0]         n_fill;
    logic [ADDRESS_WIDTH-1:0] n_pos;
    logic [LEN_W-1:0]         base_fill;
    logic [LEN_W-1:0]         len_eff;
    logic                     accept;
    logic                     res_adv;
    t_cand                    cand;

    t_byte sig_bytes [SIG_BYTES];
    t_byte cell_sig  [PATTERN_MAX];
    logic  cell_care [PATTERN_MAX];
    t_byte cell_byte [PATTERN_MAX];
    logic  hit_chain [PATTERN_MAX];

    // Configuration writes; indexes past the list are dropped.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_low    <= '0;
            r_pattern_high   <= '0;
            r_wildcard       <= '0;
            r_pattern_length <= LENGTH_W'(1);
            r_wanted         <= '0;
            r_image_base     <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_PATTERN_LOW:  r_pattern_low    <= i_cfg.data;
                REG_PATTERN_HIGH: r_pattern_high   <= i_cfg.data;
                REG_WILDCARD:     r_wildcard       <= i_cfg.data[MASK_W-1:0];
                REG_LENGTH:       r_pattern_length <= i_cfg.data[LENGTH_W-1:0];
                REG_WANTED:       r_wanted         <= i_cfg.data[WANTED_W-1:0];
                REG_IMAGE_BASE:   r_image_base     <= i_cfg.data[BASE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Effective signature length: zero acts as one, oversize as the maximum.
    always_comb begin
        if (r_pattern_length == '0) begin
            len_eff = LEN_W'(1);
        end else if (r_pattern_length > LENGTH_W'(PATTERN_MAX)) begin
            len_eff = LEN_W'(PATTERN_MAX);
        end else begin
            len_eff = LEN_W'(r_pattern_length);
        end
    end

    // Signature bytes in register order.
    always_comb begin
        for (int k = 0; k < SIG_BYTES; k++) begin
            if (k < SIG_BYTES / 2) begin
                sig_bytes[k] = r_pattern_low[k*BYTE_W +: BYTE_W];
            end else begin
                sig_bytes[k] = r_pattern_high[(k - SIG_BYTES/2)*BYTE_W +: BYTE_W];
            end
        end
    end

    // Right-align the signature onto the window: the newest byte meets the
    // last signature byte, and cells ahead of the signature do not care.
    always_comb begin
        int off;
        for (int k = 0; k < PATTERN_MAX; k++) begin
            off = k + int'(len_eff) - PATTERN_MAX;
            if (off >= 0) begin
                cell_sig[k]  = sig_bytes[4'(off)];
                cell_care[k] = ~r_wildcard[4'(off)];
            end else begin
                cell_sig[k]  = '0;
                cell_care[k] = 1'b0;
            end
        end
    end

    // Window stage handshake.
    assign i_in.ready = ~r_a_valid | res_adv;
    assign accept     = i_in.valid & i_in.ready;

    // Fill count and byte offset restart after the final byte of an image.
    assign base_fill = r_prev_last ? '0 : r_fill;
    assign n_fill    = (base_fill == LEN_W'(PATTERN_MAX)) ? base_fill : base_fill + 1'b1;
    assign n_pos     = r_prev_last ? '0 : r_pos + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_last <= 1'b1;
            r_fill      <= '0;
            r_pos       <= '0;
        end else if (accept) begin
            r_prev_last <= i_in.last_byte;
            r_fill      <= n_fill;
            r_pos       <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (accept) begin
            r_a_valid <= 1'b1;
        end else if (res_adv) begin
            r_a_valid <= 1'b0;
        end
    end

    // Match start offset for the byte held in the window stage.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_last  <= i_in.last_byte;
            r_a_start <= n_pos - ADDRESS_WIDTH'(len_eff - 1'b1);
        end
    end

    // Chain of window cells; the newest byte enters at the top cell.
    for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
        t_byte in_byte;
        logic  in_hit;

        if (k == PATTERN_MAX - 1) begin : g_top
            assign in_byte = i_in.data_byte;
        end else begin : g_mid
            assign in_byte = cell_byte[k+1];
        end

        if (k == 0) begin : g_first
            assign in_hit = 1'b1;
        end else begin : g_rest
            assign in_hit = hit_chain[k-1];
        end

        wbs_cell u_cell (
            .i_clk  (i_clk),
            .i_shift(accept),
            .i_byte (in_byte),
            .i_sig  (cell_sig[k]),
            .i_care (cell_care[k]),
            .i_hit  (in_hit),
            .o_byte (cell_byte[k]),
            .o_hit  (hit_chain[k])
        );
    end

    // Candidate needs a window holding at least the signature length.
    assign cand.valid = r_a_valid;
    assign cand.last  = r_a_last;
    assign cand.hit   = (r_fill >= len_eff) & hit_chain[PATTERN_MAX-1];

    wbs_result #(
        .ADDRESS_WIDTH(ADDRESS_WIDTH)
    ) u_result (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cand      (cand),
        .i_start     (r_a_start),
        .i_image_base(r_image_base),
        .i_wanted    (r_wanted),
        .o_adv       (res_adv),
        .o_out       (o_out)
    );

    // The fill count saturates at the window depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= LEN_W'(PATTERN_MAX))
        else $error("window fill above depth");

    // A held window stage keeps its byte while the result stage is stalled.
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && !res_adv |=> r_a_valid && $stable(r_a_start) && $stable(r_pos))
        else $error("window stage changed while stalled");

    // The first byte of a new image sits at offset zero.
    a_new_image_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && r_prev_last |=> r_pos == '0 && r_fill == LEN_W'(1))
        else $error("new image did not restart at offset zero");

endmodule
